FILE: rtl/sfd_pkg.sv
package sfd_pkg;

  localparam int unsigned DataWidth = 8;
  localparam int unsigned ApbDataWidth = 32;
  localparam int unsigned ApbAddrWidth = 4;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_START_MARKER = 2'd0,
    REG_END_MARKER   = 2'd1,
    REG_MIN_PAYLOAD  = 2'd2,
    REG_UNUSED       = 2'd3
  } sfd_reg_e;

  localparam logic [DataWidth-1:0] StartMarkerReset = 8'hAA;
  localparam logic [DataWidth-1:0] EndMarkerReset   = 8'h55;
  localparam logic [DataWidth-1:0] MinPayloadReset  = 8'd3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_START = 3'd1,
    ST_INCOMP   = 3'd2,
    ST_CHK_BAD  = 3'd3,
    ST_END_BAD  = 3'd4,
    ST_SHORT    = 3'd5
  } sfd_status_e;

endpackage

FILE: rtl/sfd_if.sv
// input beat: one received byte
interface sfd_in_if import sfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] rx_byte;
  logic                 last_in_read;

  modport source (output valid, output rx_byte, output last_in_read, input ready);
  modport sink   (input valid, input rx_byte, input last_in_read, output ready);
endinterface

// result beat: one verdict per read chunk
interface sfd_out_if import sfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  sfd_status_e          status;
  logic [DataWidth-1:0] temperature;
  logic [DataWidth-1:0] humidity;
  logic [DataWidth-1:0] led_level;

  modport source (output valid, output status, output temperature, output humidity,
                  output led_level, input ready);
  modport sink   (input valid, input status, input temperature, input humidity,
                  input led_level, output ready);
endinterface

FILE: rtl/sensor_frame_deframer.sv
// sensor frame deframer: start marker, length, payload, xor checksum, end marker
// the result beat is registered and appears in the cycle after the last byte of a chunk is taken
// throughput: one byte per cycle; a waiting result does not stall input unless a
//   second chunk ends while the first result is still held (single result register)
// reset (rst_ni low, asynchronous): hunt for start, registers back to 0xAA/0x55/3,
//   no result pending
module sensor_frame_deframer import sfd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  sfd_in_if.sink                  rx_i,
  sfd_out_if.source               res_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready
);

  // frame parser phases
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_PAYLOAD,
    PH_CHK,
    PH_END,
    PH_DONE
  } phase_e;

  // configuration registers
  logic [DataWidth-1:0] start_marker_q, end_marker_q, min_payload_q;
  sfd_reg_e             reg_sel;

  // frame state
  phase_e               phase_q, phase_d;
  logic [DataWidth-1:0] bytes_left_q, bytes_left_d;
  logic [DataWidth-1:0] pay_len_q, pay_len_d;
  logic [DataWidth-1:0] xor_q, xor_d;
  logic [DataWidth-1:0] temp_q, temp_d;
  logic [DataWidth-1:0] hum_q, hum_d;
  logic [DataWidth-1:0] led_q, led_d;
  logic                 chk_ok_q, chk_ok_d;
  sfd_status_e          held_q, held_d;

  // per-beat decode
  logic                 rx_acc;
  logic [DataWidth-1:0] pos;
  sfd_status_e          verdict;
  logic                 pay_ok;

  // result register
  logic                 res_valid_q;
  sfd_status_e          res_status_q;
  logic [DataWidth-1:0] res_temp_q, res_hum_q, res_led_q;

  // ---------------------------------------------------------------------------
  // apb register file, zero wait states
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = sfd_reg_e'(paddr[3:2]);

  always_comb begin
    unique case (reg_sel)
      REG_START_MARKER: prdata = {{(ApbDataWidth-DataWidth){1'b0}}, start_marker_q};
      REG_END_MARKER:   prdata = {{(ApbDataWidth-DataWidth){1'b0}}, end_marker_q};
      REG_MIN_PAYLOAD:  prdata = {{(ApbDataWidth-DataWidth){1'b0}}, min_payload_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= StartMarkerReset;
      end_marker_q   <= EndMarkerReset;
      min_payload_q  <= MinPayloadReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_START_MARKER: start_marker_q <= pwdata[DataWidth-1:0];
        REG_END_MARKER:   end_marker_q   <= pwdata[DataWidth-1:0];
        REG_MIN_PAYLOAD:  min_payload_q  <= pwdata[DataWidth-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input side: bytes inside a chunk always flow; the closing byte waits until
  // the result register is free or drains
  // ---------------------------------------------------------------------------
  assign rx_i.ready = !res_valid_q || res_o.ready || !rx_i.last_in_read;
  assign rx_acc     = rx_i.valid && rx_i.ready;

  // index of the current payload byte within the payload
  assign pos = pay_len_q - bytes_left_q;

  // next frame state for the byte on the input
  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    pay_len_d    = pay_len_q;
    xor_d        = xor_q;
    temp_d       = temp_q;
    hum_d        = hum_q;
    led_d        = led_q;
    chk_ok_d     = chk_ok_q;
    held_d       = held_q;

    unique case (phase_q)
      PH_HUNT: begin
        if (rx_i.rx_byte == start_marker_q) phase_d = PH_LEN;
      end
      PH_LEN: begin
        pay_len_d    = rx_i.rx_byte;
        bytes_left_d = rx_i.rx_byte;
        xor_d        = rx_i.rx_byte;
        // empty payload goes straight to the checksum byte
        phase_d      = (rx_i.rx_byte == '0) ? PH_CHK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (pos == 8'd0) temp_d = rx_i.rx_byte;
        if (pos == 8'd1) hum_d  = rx_i.rx_byte;
        if (pos == 8'd2) led_d  = rx_i.rx_byte;
        xor_d        = xor_q ^ rx_i.rx_byte;
        bytes_left_d = bytes_left_q - 8'd1;
        if (bytes_left_q == 8'd1) phase_d = PH_CHK;
      end
      PH_CHK: begin
        chk_ok_d = (rx_i.rx_byte == xor_q);
        phase_d  = PH_END;
      end
      PH_END: begin
        // verdict precedence: checksum, end marker, too short
        if (!chk_ok_q)                          held_d = ST_CHK_BAD;
        else if (rx_i.rx_byte != end_marker_q) held_d = ST_END_BAD;
        else if (pay_len_q < min_payload_q)    held_d = ST_SHORT;
        else                                    held_d = ST_OK;
        phase_d = PH_DONE;
      end
      PH_DONE: ; // rest of the chunk is ignored
      default: phase_d = PH_HUNT;
    endcase
  end

  // chunk verdict, seen on the last byte of a chunk
  always_comb begin
    unique case (phase_d)
      PH_HUNT: verdict = ST_NO_START;
      PH_DONE: verdict = held_d;
      default: verdict = ST_INCOMP;
    endcase
  end

  assign pay_ok = (verdict == ST_OK);

  // frame state and result register; the end of a chunk loads the result and
  // clears everything back to the hunt, the output beat empties the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      bytes_left_q <= '0;
      pay_len_q    <= '0;
      xor_q        <= '0;
      temp_q       <= '0;
      hum_q        <= '0;
      led_q        <= '0;
      chk_ok_q     <= 1'b0;
      held_q       <= ST_OK;
      res_valid_q  <= 1'b0;
      res_status_q <= ST_OK;
      res_temp_q   <= '0;
      res_hum_q    <= '0;
      res_led_q    <= '0;
    end else begin
      if (rx_acc && rx_i.last_in_read) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end

      if (rx_acc) begin
        if (rx_i.last_in_read) begin
          // readings are only reported for a good frame
          res_status_q <= verdict;
          res_temp_q   <= pay_ok ? temp_d : '0;
          res_hum_q    <= pay_ok ? hum_d  : '0;
          res_led_q    <= pay_ok ? led_d  : '0;
          phase_q      <= PH_HUNT;
          bytes_left_q <= '0;
          pay_len_q    <= '0;
          xor_q        <= '0;
          temp_q       <= '0;
          hum_q        <= '0;
          led_q        <= '0;
          chk_ok_q     <= 1'b0;
          held_q       <= ST_OK;
        end else begin
          phase_q      <= phase_d;
          bytes_left_q <= bytes_left_d;
          pay_len_q    <= pay_len_d;
          xor_q        <= xor_d;
          temp_q       <= temp_d;
          hum_q        <= hum_d;
          led_q        <= led_d;
          chk_ok_q     <= chk_ok_d;
          held_q       <= held_d;
        end
      end
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.status      = res_status_q;
  assign res_o.temperature = res_temp_q;
  assign res_o.humidity    = res_hum_q;
  assign res_o.led_level   = res_led_q;

endmodule

FILE: rtl/sfd_checker.sv
module sfd_checker import sfd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 rx_valid,
  input logic                 rx_ready,
  input logic                 rx_last,
  input logic                 res_valid,
  input logic                 res_ready,
  input sfd_status_e          res_status,
  input logic [DataWidth-1:0] res_temp,
  input logic [DataWidth-1:0] res_hum,
  input logic [DataWidth-1:0] res_led
);

  // a held result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before its beat");

  // every chunk end gives a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid && rx_ready && rx_last |=> res_valid)
    else $error("chunk end without result");

  // a new result only follows a chunk end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> $past(rx_valid && rx_ready && rx_last))
    else $error("result without chunk end");

  // empty output register never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid |-> rx_ready)
    else $error("input stalled with free result register");

  // readings are zero unless the frame is good
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_status != ST_OK |->
      res_temp == '0 && res_hum == '0 && res_led == '0)
    else $error("readings on a bad frame");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rx_valid   (rx_i.valid),
  .rx_ready   (rx_i.ready),
  .rx_last    (rx_i.last_in_read),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .res_status (res_o.status),
  .res_temp   (res_o.temperature),
  .res_hum    (res_o.humidity),
  .res_led    (res_o.led_level)
);
